// File: sv/tlfq_pkg.sv
// tlfq_pkg: shared types and constants of the three level feedback queue scheduler
// depends on nothing; imported by tlfq_fifo and the scheduler core
package tlfq_pkg;

    localparam int JOB_W    = 3;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int JOB_IDS  = 8;

    localparam logic [CMD_W-1:0] CMD_ADMIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLICE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DONE     = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;

    localparam logic [CNT_W-1:0] HIGH_LIMIT_RESET   = 4'd2;
    localparam logic [CNT_W-1:0] MEDIUM_LIMIT_RESET = 4'd4;
    localparam logic [CNT_W-1:0] CNT_MAX            = 4'd15;

    typedef logic [JOB_W-1:0] job_t;

    typedef struct packed {
        logic push;
        logic pop;
        job_t data;
    } fifo_op_t;

endpackage

// File: sv/three_level_feedback_queue_scheduler_core.sv
// three_level_feedback_queue_scheduler_core: command register, scheduling decision,
// per-job slice counters and result register; depends on tlfq_pkg and tlfq_fifo
// the result strobe is registered through the command register and then the result register
// throughput: one command per cycle, busy stays low; the result strobe cannot be held off
// reset: all queues empty, heads at zero, slice counters zero, limits 2 and 4
// configuration is taken in any cycle, cfg_ready stays high
module three_level_feedback_queue_scheduler_core
    import tlfq_pkg::*;
#(
    parameter int MAX_JOBS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      command,
    input  logic [JOB_W-1:0]      job_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]      cfg_data,
    output logic                  result_valid,
    output logic [JOB_W-1:0]      job_number,
    output logic [LEVEL_W-1:0]    level,
    output logic                  demoted,
    output logic [STATUS_W-1:0]   status
);

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_JOBS);

    logic                 cmd_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    job_t                 job_reg;
    logic [CNT_W-1:0]     high_limit_reg;
    logic [CNT_W-1:0]     medium_limit_reg;
    logic [CNT_W-1:0]     high_used_reg [JOB_IDS];
    logic [CNT_W-1:0]     high_used_next [JOB_IDS];
    logic [CNT_W-1:0]     medium_used_reg [JOB_IDS];
    logic [CNT_W-1:0]     medium_used_next [JOB_IDS];

    fifo_op_t             ops [3];
    job_t                 heads [3];
    logic [CW-1:0]        counts [3];

    logic                 result_valid_reg;
    job_t                 job_number_reg;
    job_t                 job_number_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   level_next;
    logic                 demoted_reg;
    logic                 demoted_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;

    logic                 queues_empty;
    logic [LEVEL_W-1:0]   top_lvl;
    job_t                 top_job;
    logic                 due;
    logic                 lower_full;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_queue
            tlfq_fifo #(
                .DEPTH (MAX_JOBS)
            ) u_fifo (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (ops[g]),
                .head_data (heads[g]),
                .count     (counts[g])
            );
        end
    endgenerate

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
            job_reg <= job_index;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_limit_reg   <= HIGH_LIMIT_RESET;
            medium_limit_reg <= MEDIUM_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HIGH_LIMIT:   high_limit_reg   <= cfg_data;
                REG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // highest non-empty queue
    always_comb
    begin
        queues_empty = 1'b0;
        top_lvl      = LEVEL_HIGH;
        top_job      = heads[0];
        lower_full   = 1'b1;
        priority if (counts[0] != '0)
        begin
            top_lvl    = LEVEL_HIGH;
            top_job    = heads[0];
            lower_full = (counts[1] == FULL_COUNT);
        end
        else if (counts[1] != '0)
        begin
            top_lvl    = LEVEL_MEDIUM;
            top_job    = heads[1];
            lower_full = (counts[2] == FULL_COUNT);
        end
        else if (counts[2] != '0)
        begin
            top_lvl = LEVEL_LOW;
            top_job = heads[2];
        end
        else
        begin
            queues_empty = 1'b1;
        end

        due = ((top_lvl == LEVEL_HIGH) && (high_used_reg[top_job] >= high_limit_reg)) ||
              ((top_lvl == LEVEL_MEDIUM) && (medium_used_reg[top_job] >= medium_limit_reg));
    end

    // scheduling decision
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ops[i] = '{push: 1'b0, pop: 1'b0, data: top_job};
        end
        high_used_next   = high_used_reg;
        medium_used_next = medium_used_reg;
        job_number_next  = job_reg;
        level_next       = LEVEL_HIGH;
        demoted_next     = 1'b0;
        status_next      = STATUS_OK;

        if (cmd_valid_reg)
        begin
            if (cmd_reg == CMD_ADMIT)
            begin
                if (counts[0] == FULL_COUNT)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ops[0].push = 1'b1;
                    ops[0].data = job_reg;
                    high_used_next[job_reg]   = '0;
                    medium_used_next[job_reg] = '0;
                end
            end
            else if (queues_empty)
            begin
                job_number_next = '0;
                status_next     = STATUS_EMPTY;
            end
            else
            begin
                job_number_next = top_job;
                level_next      = top_lvl;
                unique case (cmd_reg)
                    CMD_DISPATCH:
                    begin
                        if (top_lvl == LEVEL_HIGH && high_used_reg[top_job] != CNT_MAX)
                        begin
                            high_used_next[top_job] = high_used_reg[top_job] + 1'b1;
                        end
                        else if (top_lvl == LEVEL_MEDIUM &&
                                 medium_used_reg[top_job] != CNT_MAX)
                        begin
                            medium_used_next[top_job] = medium_used_reg[top_job] + 1'b1;
                        end
                    end
                    CMD_SLICE:
                    begin
                        ops[top_lvl].pop = 1'b1;
                        if (due && !lower_full)
                        begin
                            ops[top_lvl + 1'b1].push = 1'b1;
                            demoted_next = 1'b1;
                        end
                        else
                        begin
                            ops[top_lvl].push = 1'b1;
                        end
                    end
                    CMD_DONE:
                    begin
                        ops[top_lvl].pop = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // slice counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOB_IDS; i++)
            begin
                high_used_reg[i]   <= '0;
                medium_used_reg[i] <= '0;
            end
        end
        else
        begin
            high_used_reg   <= high_used_next;
            medium_used_reg <= medium_used_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            job_number_reg <= job_number_next;
            level_reg      <= level_next;
            demoted_reg    <= demoted_next;
            status_reg     <= status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign job_number   = job_number_reg;
    assign level        = level_reg;
    assign demoted      = demoted_reg;
    assign status       = status_reg;

    a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 2))
        else $error("result strobe without an accepted command");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_EMPTY) |->
            (job_number == '0 && level == LEVEL_HIGH && !demoted))
        else $error("empty result carries a job");

    a_demote_level: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && demoted) |-> (level != LEVEL_LOW && status == STATUS_OK))
        else $error("demotion from low level or with bad status");

    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ops[0].pop, ops[1].pop, ops[2].pop}) <= 1)
        else $error("more than one queue popped");

endmodule

// File: sv/tlfq_fifo.sv
// tlfq_fifo: circular queue of job numbers with head read, pop and push in the same cycle
// depends on tlfq_pkg for job_t and fifo_op_t
module tlfq_fifo
    import tlfq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  fifo_op_t                   op,
    output job_t                       head_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int HW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = HW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [HW-1:0] LAST    = HW'(DEPTH - 1);

    job_t            mem_reg [DEPTH];
    logic [HW-1:0]   head_reg;
    logic [HW-1:0]   head_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [SW-1:0]   tail_sum;
    logic [HW-1:0]   tail;

    // tail from the old head and count is also right after a same-cycle pop
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail = tail_sum[HW-1:0];

        head_next = head_reg;
        if (op.pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end

        count_next = count_reg;
        if (op.push && !op.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.pop && !op.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem_reg[tail] <= op.data;
        end
    end

    assign head_data = mem_reg[head_reg];
    assign count     = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push && !op.pop) |-> count_reg != CW'(DEPTH))
        else $error("push into full queue");

endmodule
